### hw/rtl/h263_rfc2190_depacketizer_core_macros.svh
// Assertion macros shared by the depacketizer RTL.
// Every macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef H263_RFC2190_DEPACKETIZER_CORE_MACROS_SVH
`define H263_RFC2190_DEPACKETIZER_CORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define H263_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define H263_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/h263dp_pkg.sv
package h263dp_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_ALIGN    = 3'd2;
  localparam logic [2:0] ST_NOPRIOR  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [3:0] HDR_LEN_A = 4'd4;
  localparam logic [3:0] HDR_LEN_B = 4'd8;
  localparam logic [3:0] HDR_LEN_C = 4'd12;

  localparam logic [15:0] MAX_FRAME_RESET = 16'hffff;

  // One output word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } word_t;

  // Work handed from the front end to the back end for one input byte.
  // A second word, when present, is always the frame's final byte with status OK.
  typedef struct packed {
    word_t      first;
    logic       second_valid;
    logic [7:0] second_data;
  } cmd_t;

  // Mask covering the low n bits of a byte.
  function automatic logic [7:0] low_mask(input logic [2:0] n);
    low_mask = 8'hff >> (4'd8 - {1'b0, n});
  endfunction

endpackage

### hw/rtl/h263dp_front.sv
module h263dp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                frag_first,
  input  logic                frag_last,
  input  logic                frame_last,
  input  logic [15:0]         max_frame_bytes,
  output h263dp_pkg::cmd_t    cmd,
  output logic                cmd_valid
);
  import h263dp_pkg::*;

  logic [7:0]  held_byte;
  logic        held_valid;
  logic [2:0]  prev_end_bits;
  logic [2:0]  cur_start_bits;
  logic [2:0]  cur_end_bits;
  logic [3:0]  header_length;
  logic [15:0] byte_in_fragment;
  logic [15:0] bytes_emitted;
  logic        discarding;

  logic [15:0] pos;
  logic [15:0] pos_inc;
  logic [15:0] hdr_len_ext;
  logic        at_head;
  logic        ends;
  logic [2:0]  start_bits;
  logic [2:0]  end_bits;
  logic [3:0]  hdr_len;
  logic [2:0]  align_sum;
  logic [2:0]  err;
  logic        emit_old;
  logic [7:0]  held_byte_next;
  logic        held_valid_next;
  logic [15:0] bytes_emitted_next;

  always_comb begin
    pos         = frag_first ? 16'd0 : byte_in_fragment;
    pos_inc     = (pos != 16'hffff) ? pos + 16'd1 : pos;
    at_head     = (pos == 16'd0);
    ends        = frag_last | frame_last;
    start_bits  = at_head ? in_byte[5:3] : cur_start_bits;
    end_bits    = at_head ? in_byte[2:0] : cur_end_bits;
    if (!at_head) begin
      hdr_len = header_length;
    end else if (!in_byte[7]) begin
      hdr_len = HDR_LEN_A;
    end else if (!in_byte[6]) begin
      hdr_len = HDR_LEN_B;
    end else begin
      hdr_len = HDR_LEN_C;
    end
    hdr_len_ext = {12'd0, hdr_len};
    align_sum   = start_bits + prev_end_bits;

    err                = ST_OK;
    emit_old           = 1'b0;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    bytes_emitted_next = bytes_emitted;

    // The alignment check falls on the last byte of the shortest header.
    if (pos == 16'd3 && align_sum != 3'd0) begin
      err = ST_ALIGN;
    end

    if (err == ST_OK && pos >= hdr_len_ext) begin
      if (pos == hdr_len_ext && start_bits != 3'd0) begin
        // Leading partial byte merges into the tail of the previous fragment.
        if (!held_valid) begin
          err = ST_NOPRIOR;
        end else begin
          held_byte_next = held_byte | (in_byte & low_mask(start_bits));
        end
      end else if (bytes_emitted >= max_frame_bytes) begin
        err = ST_OVERFLOW;
      end else begin
        emit_old           = held_valid;
        held_byte_next     = in_byte;
        held_valid_next    = 1'b1;
        bytes_emitted_next = bytes_emitted + 16'd1;
      end
    end

    if (err == ST_OK && ends && pos < hdr_len_ext) begin
      err = ST_SHORT;
    end

    cmd.first.data    = 8'd0;
    cmd.first.last    = 1'b0;
    cmd.first.status  = ST_OK;
    cmd.second_valid  = 1'b0;
    cmd.second_data   = held_byte_next;
    cmd_valid         = 1'b0;
    if (discarding) begin
      cmd_valid = 1'b0;
    end else if (err != ST_OK) begin
      cmd.first.last   = 1'b1;
      cmd.first.status = err;
      cmd_valid        = 1'b1;
    end else if (emit_old) begin
      cmd.first.data   = held_byte;
      cmd.second_valid = frame_last;
      cmd_valid        = 1'b1;
    end else if (frame_last && held_valid_next) begin
      cmd.first.data = held_byte_next;
      cmd.first.last = 1'b1;
      cmd_valid      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    // Every frame end clears the frame state, whatever else happened.
    if (rst || (accept && frame_last)) begin
      held_byte        <= 8'd0;
      held_valid       <= 1'b0;
      prev_end_bits    <= 3'd0;
      cur_start_bits   <= 3'd0;
      cur_end_bits     <= 3'd0;
      header_length    <= HDR_LEN_A;
      byte_in_fragment <= 16'd0;
      bytes_emitted    <= 16'd0;
      discarding       <= 1'b0;
    end else if (accept && !discarding) begin
      cur_start_bits <= start_bits;
      cur_end_bits   <= end_bits;
      header_length  <= hdr_len;
      if (err != ST_OK) begin
        held_byte  <= 8'd0;
        held_valid <= 1'b0;
        discarding <= 1'b1;
      end else begin
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        bytes_emitted <= bytes_emitted_next;
        if (ends) begin
          prev_end_bits    <= end_bits;
          byte_in_fragment <= 16'd0;
        end else begin
          byte_in_fragment <= pos_inc;
        end
      end
    end
  end

endmodule

### hw/rtl/h263dp_queue.sv
module h263dp_queue #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/h263dp_back.sv
module h263dp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  h263dp_pkg::cmd_t  q_data,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [2:0]        m_tuser
);
  import h263dp_pkg::*;

  word_t      out_word;
  logic       out_valid;
  logic       pend_valid;
  logic [7:0] pend_data;
  logic       load;

  // The output register can take a new word when empty or being drained.
  assign load  = !out_valid || m_tready;
  assign q_pop = load && !pend_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= q_data.second_valid;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_word.data   <= pend_data;
        out_word.last   <= 1'b1;
        out_word.status <= ST_OK;
      end else if (q_valid) begin
        out_word  <= q_data.first;
        pend_data <= q_data.second_data;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word.data;
  assign m_tlast  = out_word.last;
  assign m_tuser  = out_word.status;

endmodule

### hw/rtl/h263_rfc2190_depacketizer_core.sv
// RFC 2190 H.263 payload depacketizer.
// The s_ channel takes raw fragment bytes, header included, one word per cycle while ready:
// tuser[0] marks a fragment's first byte, tuser[1] its last, tlast the frame's last byte.
// The m_ channel returns the reassembled bitstream; tuser carries a status code and
// tlast marks the frame's final word. An error gives one word with data 0, tlast set
// and a nonzero status, after which the rest of the frame is dropped.
// The cfg channel writes max_frame_bytes and is always ready; write it only while idle.
// Throughput: one input byte per cycle while s_tready is high. The front end classifies each
// byte combinationally; the back end drives one output word per cycle from a short command
// queue while m_tready is high. A frame end that releases two words queues one command for both.
// A word caused by an accepted byte is written into the queue, then loaded into the back end's
// output register and presented on m_. Payload bytes themselves leave one byte late, since
// each byte is held until the next one shows it is not merged with a partial byte.
// When m_tready is low, words pile up in the QUEUE_DEPTH-entry queue and s_tready drops
// once it is full. Reset empties the queue, clears the frame state and sets
// max_frame_bytes to 65535.
`include "h263_rfc2190_depacketizer_core_macros.svh"

module h263_rfc2190_depacketizer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic [1:0]  s_tuser,   // [0] frag_first, [1] frag_last
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import h263dp_pkg::*;

  logic [15:0] max_frame_bytes;
  logic        accept;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  cmd_t        cmd;
  logic        cmd_valid;
  cmd_t        q_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_bytes <= cfg_data;
    end
  end

  h263dp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .in_byte         (s_tdata),
    .frag_first      (s_tuser[0]),
    .frag_last       (s_tuser[1]),
    .frame_last      (s_tlast),
    .max_frame_bytes (max_frame_bytes),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid)
  );

  h263dp_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && cmd_valid),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  h263dp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // An error word always closes what the frame delivers.
  `H263_ASSERT(a_error_is_last, m_tvalid && m_tuser != ST_OK |-> m_tlast, "error word without tlast")
  // Status codes beyond overflow are never produced.
  `H263_ASSERT_NEVER(a_status_range, m_tvalid && m_tuser > ST_OVERFLOW, "undefined status code")
  // A byte that causes output leaves work in the queue for the back end.
  `H263_ASSERT(a_push_lands, accept && cmd_valid |=> q_valid, "queued word lost")

endmodule
